>>> hdl/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared constants, operation codes and control structs of the indexed list
// engine.
// ----------------------------------------------------------------------------
package ilist_pkg;

    // list size and field widths
    localparam int CAPACITY  = 32;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int TDATA_W   = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - DATA_W - POS_W;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TUSER_W = 2;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

    // work plan chosen when an item is taken
    localparam int PLAN_W = 3;
    localparam logic [PLAN_W-1:0] PLAN_NONE     = 3'd0;
    localparam logic [PLAN_W-1:0] PLAN_PUT      = 3'd1;
    localparam logic [PLAN_W-1:0] PLAN_SHIFT_UP = 3'd2;
    localparam logic [PLAN_W-1:0] PLAN_SHIFT_DN = 3'd3;
    localparam logic [PLAN_W-1:0] PLAN_DEC      = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the incoming item
        logic shift_rd;  // read one entry of a shift and advance
        logic put;       // write the new value, count up
        logic dec;       // count down
        logic list;      // emit list entries
    } ilist_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [PLAN_W-1:0] plan;
        logic              shift_last;
        logic              shift_up;
        logic              list_done;
        logic              pend;
    } ilist_sts_t;

endpackage

>>> hdl/ilist_ram.sv
// ----------------------------------------------------------------------------
// ilist_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ilist_dpath.sv
// ----------------------------------------------------------------------------
// ilist_dpath
// Element store, count, shift pipeline and listing output register.
// ----------------------------------------------------------------------------
module ilist_dpath
    import ilist_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ilist_cmd_t               cmd,
    output ilist_sts_t               sts,
    input  logic [KIND_W-1:0]        in_kind,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic [POS_W-1:0]         in_pos,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_value,
    output logic [POS_W-1:0]         out_pos,
    output logic                     out_empty,
    output logic                     out_last,
    output logic                     out_dropped
);

    // control registers
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wpend_reg, wpend_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [DATA_W-1:0] value_reg, value_next;
    logic              dropped_reg, dropped_next;
    logic              up_reg, up_next;
    logic [IDX_W-1:0]  put_addr_reg, put_addr_next;
    logic [IDX_W-1:0]  rd_reg, rd_next;
    logic [IDX_W-1:0]  waddr_reg, waddr_next;
    logic [IDX_W-1:0]  list_idx_reg, list_idx_next;
    logic              pend_empty_reg, pend_empty_next;
    logic              pend_last_reg, pend_last_next;
    logic [IDX_W-1:0]  pend_pos_reg, pend_pos_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_last_reg, out_last_next;
    logic              out_dropped_reg, out_dropped_next;

    // decode and memory signals
    logic              is_ins, full, pos_hit, tail_del;
    logic [CMP_W-1:0]  pos_ext, count_ext;
    logic [PLAN_W-1:0] plan;
    logic              load_out, issue, list_last, shift_last;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    ilist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pick the work plan for the incoming item
    always_comb begin
        pos_ext   = CMP_W'(in_pos);
        count_ext = CMP_W'(count_reg);
        is_ins    = (in_kind == KIND_FRONT) || (in_kind == KIND_BACK);
        full      = (count_reg == CNT_W'(CAPACITY));
        pos_hit   = (pos_ext < count_ext);
        tail_del  = ((pos_ext + CMP_W'(1)) == count_ext);
        plan      = PLAN_NONE;
        unique case (in_kind) inside
            KIND_FRONT, KIND_BACK: begin
                if (full) begin
                    plan = PLAN_NONE;
                end else if ((in_kind == KIND_FRONT) && (count_reg != '0)) begin
                    plan = PLAN_SHIFT_UP;
                end else begin
                    plan = PLAN_PUT;
                end
            end
            KIND_DEL: begin
                if (!pos_hit) begin
                    plan = PLAN_NONE;
                end else if (tail_del) begin
                    plan = PLAN_DEC;
                end else begin
                    plan = PLAN_SHIFT_DN;
                end
            end
            default: plan = PLAN_NONE;
        endcase
    end

    // listing handshake and end-of-run detection
    always_comb begin
        load_out   = pend_reg && (!out_valid_reg || out_ready);
        issue      = cmd.list && (!pend_reg || load_out);
        list_last  = (count_reg == '0) ||
                     (list_idx_reg == IDX_W'(count_reg - CNT_W'(1)));
        shift_last = up_reg ? (rd_reg == '0)
                            : (rd_reg == IDX_W'(count_reg - CNT_W'(1)));
    end

    // memory ports: shift reads and list reads share the read port
    always_comb begin
        ram_re    = cmd.shift_rd || (issue && (count_reg != '0));
        ram_raddr = cmd.shift_rd ? rd_reg : list_idx_reg;
        ram_we    = wpend_reg || cmd.put;
        ram_waddr = wpend_reg ? waddr_reg : put_addr_reg;
        ram_wdata = wpend_reg ? ram_rdata : value_reg;
    end

    // next state
    always_comb begin
        count_next       = count_reg;
        value_next       = value_reg;
        dropped_next     = dropped_reg;
        up_next          = up_reg;
        put_addr_next    = put_addr_reg;
        rd_next          = rd_reg;
        waddr_next       = waddr_reg;
        list_idx_next    = list_idx_reg;
        wpend_next       = cmd.shift_rd;
        pend_next        = pend_reg;
        pend_empty_next  = pend_empty_reg;
        pend_last_next   = pend_last_reg;
        pend_pos_next    = pend_pos_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_pos_next     = out_pos_reg;
        out_empty_next   = out_empty_reg;
        out_last_next    = out_last_reg;
        out_dropped_next = out_dropped_reg;

        // latch the item and set up the shift
        if (cmd.load) begin
            value_next    = in_value;
            dropped_next  = is_ins && full;
            up_next       = (in_kind == KIND_FRONT);
            put_addr_next = (in_kind == KIND_FRONT) ? '0 : IDX_W'(count_reg);
            rd_next       = (in_kind == KIND_FRONT) ? IDX_W'(count_reg - CNT_W'(1))
                                                    : IDX_W'(pos_ext + CMP_W'(1));
            list_idx_next = '0;
        end

        // advance the shift; the write lands in the next cycle
        if (cmd.shift_rd) begin
            waddr_next = up_reg ? (rd_reg + IDX_W'(1)) : (rd_reg - IDX_W'(1));
            rd_next    = up_reg ? (rd_reg - IDX_W'(1)) : (rd_reg + IDX_W'(1));
        end

        if (cmd.put) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.dec) begin
            count_next = count_reg - CNT_W'(1);
        end

        // hand the read data over to the output register
        if (load_out) begin
            out_value_next   = pend_empty_reg ? '0 : ram_rdata;
            out_pos_next     = POS_W'(pend_pos_reg);
            out_empty_next   = pend_empty_reg;
            out_last_next    = pend_last_reg;
            out_dropped_next = dropped_reg;
            out_valid_next   = 1'b1;
            pend_next        = 1'b0;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        // issue the next list entry
        if (issue) begin
            pend_next       = 1'b1;
            pend_empty_next = (count_reg == '0);
            pend_last_next  = list_last;
            pend_pos_next   = list_idx_reg;
            list_idx_next   = list_idx_reg + IDX_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            wpend_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            wpend_reg     <= wpend_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        value_reg       <= value_next;
        dropped_reg     <= dropped_next;
        up_reg          <= up_next;
        put_addr_reg    <= put_addr_next;
        rd_reg          <= rd_next;
        waddr_reg       <= waddr_next;
        list_idx_reg    <= list_idx_next;
        pend_empty_reg  <= pend_empty_next;
        pend_last_reg   <= pend_last_next;
        pend_pos_reg    <= pend_pos_next;
        out_value_reg   <= out_value_next;
        out_pos_reg     <= out_pos_next;
        out_empty_reg   <= out_empty_next;
        out_last_reg    <= out_last_next;
        out_dropped_reg <= out_dropped_next;
    end

    // status and outputs
    assign sts.plan       = plan;
    assign sts.shift_last = shift_last;
    assign sts.shift_up   = up_reg;
    assign sts.list_done  = issue && list_last;
    assign sts.pend       = pend_reg;

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_pos     = out_pos_reg;
    assign out_empty   = out_empty_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_dropped_reg;

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(wpend_reg && cmd.put))
        else $error("shift write collides with new value write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.list |-> !wpend_reg)
        else $error("list read while a shift write is outstanding");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dec |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("delete did not lower the count");

endmodule

>>> hdl/ilist_ctrl.sv
// ----------------------------------------------------------------------------
// ilist_ctrl
// Sequencer: takes an item, runs its shift, write or count-down, then the listing.
// ----------------------------------------------------------------------------
module ilist_ctrl
    import ilist_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ilist_sts_t sts,
    output ilist_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_PUT   = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_LIST  = 3'd5;

    logic [2:0] state_reg, state_next;

    // decode state into commands and the next state
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = !sts.pend;
                if (in_valid && !sts.pend) begin
                    cmd.load = 1'b1;
                    unique case (sts.plan) inside
                        PLAN_SHIFT_UP, PLAN_SHIFT_DN: state_next = ST_SHIFT;
                        PLAN_PUT:                     state_next = ST_PUT;
                        PLAN_DEC:                     state_next = ST_DEC;
                        default:                      state_next = ST_LIST;
                    endcase
                end
            end
            ST_SHIFT: begin
                cmd.shift_rd = 1'b1;
                if (sts.shift_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = sts.shift_up ? ST_PUT : ST_DEC;
            end
            ST_PUT: begin
                cmd.put    = 1'b1;
                state_next = ST_LIST;
            end
            ST_DEC: begin
                cmd.dec    = 1'b1;
                state_next = ST_LIST;
            end
            ST_LIST: begin
                cmd.list = 1'b1;
                if (sts.list_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values with front/back insert and delete.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel carries one operation: insert at front,
// insert at back, delete at a position, or no change (kind in s_tuser).
// After the operation the whole list goes out on the m_ channel front to
// back, one transfer per element with m_tlast on the final one; an empty
// list gives one transfer with the empty flag set in m_tuser. A refused
// insert (list full) sets the dropped flag on every transfer of that run.
// Sequence with a ready receiver: the item is taken in the idle state; a
// back insert or a tail delete then goes to its update state, a front
// insert into a non-empty list or a middle delete shifts the store one
// entry per cycle through the memory's single write port and then passes
// a drain and an update state, and a no-change, refused or out-of-range
// operation goes straight to the listing. The listing issues one element
// per cycle while the receiver keeps up, and each element passes a pending
// stage and then the output register; s_tready stays low from acceptance
// until the last element is in the output register. A stalled receiver
// holds the output register and pauses the listing without loss. Reset
// empties the list and returns the engine to idle with s_tready high.
// ----------------------------------------------------------------------------
module indexed_list_engine
    import ilist_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [31:0] new_value, [37:32] position
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [31:0] item_value, [37:32] item_position
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] list_empty, [1] insert_dropped
    output logic                 m_tlast
);

    ilist_cmd_t               cmd;
    ilist_sts_t               sts;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         out_pos;
    logic                     out_empty;
    logic                     out_dropped;

    ilist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ilist_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (s_tuser[KIND_W-1:0]),
        .in_value    (s_tdata[DATA_W-1:0]),
        .in_pos      (s_tdata[DATA_W +: POS_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (out_value),
        .out_pos     (out_pos),
        .out_empty   (out_empty),
        .out_last    (m_tlast),
        .out_dropped (out_dropped)
    );

    // pack the result transfer
    assign m_tdata = {{PAD_W{1'b0}}, out_pos, out_value};
    assign m_tuser = {out_dropped, out_empty};

endmodule

>>> tb/tb_indexed_list_engine.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// Self-checking testbench for the indexed list engine.
// ----------------------------------------------------------------------------
// Operations go in on the s_ channel. A shadow list in the testbench applies
// each accepted operation and queues the full listing that the block should
// send. Every transfer on the m_ channel is checked field by field against
// the oldest queued entry. The run covers empty, one- and two-element lists,
// field extremes, a full list with refused inserts, deletes past the end,
// a random grow and shrink walk, random sender bursts, receiver stalls, and
// a long output hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine;
    import ilist_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 80;

    // receiver behavior
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  index;
        logic              empty;
        logic              last;
        logic              dropped;
    } listing_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;   // [31:0] new_value, [37:32] position
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // [1:0] kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;         // [31:0] item_value, [37:32] item_position
    logic [M_TUSER_W-1:0] m_tuser;         // [0] list_empty, [1] insert_dropped
    logic                 m_tlast;

    logic [DATA_W-1:0] shadow_list[$];
    listing_t          pending_listing[$];

    int failures        = 0;
    int ops_sent        = 0;
    int results_checked = 0;
    int refused_inserts = 0;
    int empty_listings  = 0;
    int full_listings   = 0;
    int cycle_count     = 0;

    int rx_mode       = RX_ALWAYS;
    int rx_hold_len   = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int rx_phase      = 0;

    bit pacing_on  = 1'b0;
    int burst_left = 0;

    indexed_list_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_listing.size());
            $display("indexed_list_engine verification failed");
            $finish;
        end
    end

    // apply one operation to the shadow list and queue the listing it causes
    task automatic predict_listing(input logic [KIND_W-1:0] kind,
                                   input logic [DATA_W-1:0] value,
                                   input logic [POS_W-1:0]  pos);
        listing_t entry;
        logic     dropped;
        int       n;
        dropped = 1'b0;
        case (kind) inside
            KIND_FRONT, KIND_BACK: begin
                if (shadow_list.size() >= CAPACITY) begin
                    dropped = 1'b1;
                    refused_inserts++;
                end else if (kind == KIND_FRONT) begin
                    shadow_list.push_front(value);
                end else begin
                    shadow_list.push_back(value);
                end
            end
            KIND_DEL: begin
                if (int'(pos) < shadow_list.size())
                    shadow_list.delete(int'(pos));
            end
            default: ;
        endcase
        n = shadow_list.size();
        if (n == 0) begin
            entry = '{value: '0, index: '0, empty: 1'b1, last: 1'b1, dropped: dropped};
            pending_listing.push_back(entry);
            empty_listings++;
        end else begin
            if (n == CAPACITY)
                full_listings++;
            for (int i = 0; i < n; i++) begin
                entry.value   = shadow_list[i];
                entry.index   = POS_W'(i);
                entry.empty   = 1'b0;
                entry.last    = (i == n - 1);
                entry.dropped = dropped;
                pending_listing.push_back(entry);
            end
        end
    endtask

    // offer one operation and hold it until the transfer happens
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic [DATA_W-1:0] value,
                           input logic [POS_W-1:0]  pos);
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, pos, value};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        ops_sent++;
        predict_listing(kind, value, pos);
        if (pacing_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(1, 45)
                                                  : $urandom_range(1, 6))
                    @(posedge aclk);
                burst_left = $urandom_range(0, 7);
            end
        end
    endtask

    // drop valid and wait until every queued result has arrived
    task automatic wait_drained(input int extra);
        s_tvalid <= 1'b0;
        while (pending_listing.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // receiver: long holds on request, otherwise the current stall pattern
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = rx_hold_len;
        end
        rx_phase = (rx_phase + 1) % 7;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:  m_tready <= ($urandom_range(0, 99) < 65);
                RX_PATTERN: m_tready <= (rx_phase != 2 && rx_phase != 3 && rx_phase != 5);
                default:    m_tready <= aresetn;
            endcase
        end
    end

    // compare each result transfer with the oldest queued listing entry
    always @(posedge aclk) begin : check_listing
        listing_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_listing.size() == 0) begin
                $error("result with nothing queued: item_value %h item_position %0d",
                       m_tdata[DATA_W-1:0], m_tdata[DATA_W+POS_W-1:DATA_W]);
                failures++;
            end else begin
                want = pending_listing.pop_front();
                results_checked++;
                if (m_tdata[DATA_W-1:0] !== want.value) begin
                    $error("item_value expected %h got %h", want.value, m_tdata[DATA_W-1:0]);
                    failures++;
                end
                if (m_tdata[DATA_W+POS_W-1:DATA_W] !== want.index) begin
                    $error("item_position expected %0d got %0d",
                           want.index, m_tdata[DATA_W+POS_W-1:DATA_W]);
                    failures++;
                end
                if (m_tuser[0] !== want.empty) begin
                    $error("list_empty expected %b got %b", want.empty, m_tuser[0]);
                    failures++;
                end
                if (m_tlast !== want.last) begin
                    $error("last expected %b got %b", want.last, m_tlast);
                    failures++;
                end
                if (m_tuser[1] !== want.dropped) begin
                    $error("insert_dropped expected %b got %b", want.dropped, m_tuser[1]);
                    failures++;
                end
            end
        end
    end

    // empty, one and two element lists, field extremes, every kind
    task automatic test_edges();
        rx_mode   = RX_ALWAYS;
        pacing_on = 1'b0;
        send_op(KIND_NOP,   32'hffff_ffff, 6'd63);
        send_op(KIND_DEL,   32'hffff_ffff, 6'd0);
        send_op(KIND_FRONT, 32'h7fff_ffff, 6'd63);
        send_op(KIND_DEL,   32'h0,         6'd1);
        send_op(KIND_BACK,  32'h8000_0000, 6'd0);
        send_op(KIND_FRONT, 32'h0,         6'd42);
        send_op(KIND_BACK,  32'hffff_ffff, 6'd21);
        send_op(KIND_DEL,   32'h5555_5555, 6'd63);
        send_op(KIND_DEL,   32'haaaa_aaaa, 6'd4);
        send_op(KIND_DEL,   32'h0,         6'd3);
        send_op(KIND_DEL,   32'h0,         6'd0);
        rx_mode = RX_PATTERN;
        send_op(KIND_BACK,  32'h0000_0005, 6'd0);
        send_op(KIND_BACK,  32'h0000_0006, 6'd0);
        send_op(KIND_DEL,   32'h0,         6'd1);
        send_op(KIND_NOP,   32'h1234_5678, 6'd0);
        send_op(KIND_DEL,   32'h0,         6'd0);
        send_op(KIND_DEL,   32'h0,         6'd0);
        send_op(KIND_DEL,   32'h0,         6'd0);
        send_op(KIND_NOP,   32'h0,         6'd0);
        wait_drained(4);
    endtask

    // fill to capacity, refuse inserts at both ends, then trim both ends
    task automatic test_full_list();
        rx_mode   = RX_RANDOM;
        pacing_on = 1'b1;
        while (shadow_list.size() < CAPACITY)
            send_op($urandom_range(0, 1) ? KIND_FRONT : KIND_BACK, pick_value(),
                    POS_W'($urandom()));
        send_op(KIND_FRONT, pick_value(), 6'd0);
        send_op(KIND_BACK,  pick_value(), 6'd63);
        send_op(KIND_DEL,   '0,           POS_W'(CAPACITY - 1));
        send_op(KIND_DEL,   '0,           6'd0);
        send_op(KIND_DEL,   '0,           POS_W'(CAPACITY));
        send_op(KIND_FRONT, pick_value(), 6'd0);
        send_op(KIND_BACK,  pick_value(), 6'd0);
        send_op(KIND_BACK,  pick_value(), 6'd0);
        send_op(KIND_NOP,   pick_value(), 6'd0);
        wait_drained(4);
    endtask

    // random walk that grows the list to full and shrinks it back
    task automatic test_random_walk(input int n_ops);
        bit growing;
        int roll;
        int n;
        growing   = 1'b1;
        pacing_on = 1'b1;
        for (int k = 0; k < n_ops; k++) begin
            if (k % 50 == 0)
                rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
            n = shadow_list.size();
            if (n == 0)
                growing = 1'b1;
            else if (n == CAPACITY && $urandom_range(0, 99) < 40)
                growing = 1'b0;
            else if (!growing && n < 6 && $urandom_range(0, 99) < 20)
                growing = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                // noise: any kind, any fields
                send_op(KIND_W'($urandom()), $urandom(), POS_W'($urandom()));
            end else if (growing) begin
                if (roll < 75)
                    send_op($urandom_range(0, 1) ? KIND_FRONT : KIND_BACK, pick_value(),
                            POS_W'($urandom()));
                else if (roll < 85)
                    send_op(KIND_NOP, $urandom(), POS_W'($urandom()));
                else
                    send_op(KIND_DEL, $urandom(), POS_W'($urandom_range(0, n)));
            end else begin
                if (roll < 70)
                    send_op(KIND_DEL, $urandom(), POS_W'($urandom_range(0, n - 1)));
                else if (roll < 80)
                    send_op(KIND_DEL, $urandom(), POS_W'($urandom()));
                else if (roll < 90)
                    send_op($urandom_range(0, 1) ? KIND_FRONT : KIND_BACK, pick_value(),
                            POS_W'($urandom()));
                else
                    send_op(KIND_NOP, $urandom(), POS_W'($urandom()));
            end
        end
        wait_drained(4);
    endtask

    // hold the output off while the sender keeps offering, then pause the sender
    task automatic test_output_hold();
        rx_mode     = RX_ALWAYS;
        pacing_on   = 1'b0;
        rx_hold_len = 400;
        hold_requests++;
        for (int k = 0; k < 8; k++)
            send_op(KIND_W'($urandom_range(0, 3)), pick_value(),
                    POS_W'($urandom_range(0, 40)));
        wait_drained(4);
        rx_mode = RX_RANDOM;
        for (int k = 0; k < 4; k++)
            send_op(KIND_BACK, pick_value(), POS_W'($urandom()));
        wait_drained(4);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_full_list();
        test_output_hold();
        test_random_walk(180);
        rx_mode = RX_ALWAYS;
        wait_drained(SETTLE_CYCLES);
        $display("covered %0d operations, %0d result transfers checked", ops_sent,
                 results_checked);
        $display("full listings %0d, refused inserts %0d, empty listings %0d",
                 full_listings, refused_inserts, empty_listings);
        if (failures == 0)
            $display("indexed_list_engine verification clean");
        else
            $display("indexed_list_engine verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/ilist_pkg.sv
hdl/ilist_ram.sv
hdl/ilist_dpath.sv
hdl/ilist_ctrl.sv
hdl/indexed_list_engine.sv
tb/tb_indexed_list_engine.sv
